// ----- design/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap fit allocator
// Sizes of the unit map, field widths, policy codes, sequencer states and
// the structs that travel between the allocator's modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Map geometry
    localparam int UNITS     = 1024;
    localparam int WORD_W    = (UNITS >= 32) ? 32 : (2 ** $clog2(UNITS));
    localparam int LOC_W     = $clog2(WORD_W);
    localparam int WORDS     = (UNITS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W     = WADDR_W + LOC_W;
    localparam int SLICE_W   = 8;
    localparam int SLICES    = WORD_W / SLICE_W;
    localparam int SL_W      = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int CNT_W     = $clog2(UNITS + 1);

    // Field widths of the transfer payloads
    localparam int OPC_W     = 2;
    localparam int SIZE_W    = 11;
    localparam int START_W   = 10;
    localparam int PCNT_W    = 11;

    localparam logic [PCNT_W-1:0] COUNT_MAX = {PCNT_W{1'b1}};

    // Policy codes
    localparam logic [OPC_W-1:0] OP_FIRST = 2'd0;
    localparam logic [OPC_W-1:0] OP_BEST  = 2'd1;
    localparam logic [OPC_W-1:0] OP_WORST = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [SIZE_W-1:0] request_size;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_unit;
        logic [PCNT_W-1:0]  policy_count;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_CLOSE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } state_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic               clear;
        logic               step;
        logic               close;
        logic [OPC_W-1:0]   policy;
        logic [CNT_W-1:0]   size;
        logic [SLICE_W-1:0] bits;
        logic [POS_W-1:0]   base;
    } scan_ctrl_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic             found;
        logic             hit;
        logic [POS_W-1:0] pick_start;
    } scan_stat_t;

    // Map memory write port
    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] addr;
        logic [WORD_W-1:0]  data;
    } ram_wr_t;

endpackage

// ----- design/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// bfa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                      rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- design/bfa_scan.sv -----
// ----------------------------------------------------------------------------
// bfa_scan: shared hole scan unit
// Walks one 8-unit slice of the map per step, tracking the current free
// run and the hole picked so far under the requested policy.
// ----------------------------------------------------------------------------
module bfa_scan
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctrl_t ctrl,
    output scan_stat_t stat
);

    logic [POS_W-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic             found_reg, found_next;
    logic             hit_reg, hit_next;
    logic [POS_W-1:0] pick_start_reg, pick_start_next;
    logic [CNT_W-1:0] pick_len_reg, pick_len_next;

    // one slice of run tracking; the extra last step closes the final run
    always_comb
    begin
        logic [POS_W:0] pos;
        logic           act;
        logic           free;

        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;

        for (int k = 0; k <= SLICE_W; k++)
        begin
            pos  = {1'b0, ctrl.base} + (POS_W+1)'(k);
            act  = (k < SLICE_W) ? ctrl.step : ctrl.close;
            free = (k < SLICE_W) && !ctrl.bits[k % SLICE_W]
                   && (pos < (POS_W+1)'(UNITS));
            if (act && !hit_next)
            begin
                if (free)
                begin
                    if (run_len_next == '0)
                    begin
                        run_start_next = pos[POS_W-1:0];
                    end
                    run_len_next = run_len_next + 1'b1;
                    if (ctrl.policy == OP_FIRST && run_len_next == ctrl.size)
                    begin
                        found_next      = 1'b1;
                        hit_next        = 1'b1;
                        pick_start_next = run_start_next;
                        pick_len_next   = run_len_next;
                    end
                end
                else
                begin
                    if (run_len_next != '0 && run_len_next >= ctrl.size &&
                        (!found_next ||
                         (ctrl.policy == OP_BEST  && run_len_next < pick_len_next) ||
                         (ctrl.policy == OP_WORST && run_len_next > pick_len_next)))
                    begin
                        found_next      = 1'b1;
                        pick_start_next = run_start_next;
                        pick_len_next   = run_len_next;
                    end
                    run_len_next = '0;
                end
            end
        end

        if (ctrl.clear)
        begin
            run_start_next  = '0;
            run_len_next    = '0;
            found_next      = 1'b0;
            hit_next        = 1'b0;
            pick_start_next = '0;
            pick_len_next   = '0;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            found_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            pick_start_reg <= '0;
            pick_len_reg   <= '0;
        end
        else
        begin
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            found_reg      <= found_next;
            hit_reg        <= hit_next;
            pick_start_reg <= pick_start_next;
            pick_len_reg   <= pick_len_next;
        end
    end

    assign stat.found      = found_reg;
    assign stat.hit        = hit_reg;
    assign stat.pick_start = pick_start_reg;

endmodule

// ----- design/bfa_seq.sv -----
// ----------------------------------------------------------------------------
// bfa_seq: allocator sequencer
// Takes a request, streams map words through the scan unit, marks the
// chosen run with read-modify-write passes and keeps the policy counters.
// ----------------------------------------------------------------------------
module bfa_seq
    import bfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  req_t               req,
    output logic               busy,
    output logic               result_valid,
    output result_t            result,
    output scan_ctrl_t         scan_ctrl,
    input  scan_stat_t         scan_stat,
    output ram_wr_t            ram_wr,
    output logic [WADDR_W-1:0] ram_raddr,
    input  logic [WORD_W-1:0]  ram_rdata
);

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    localparam logic [SL_W-1:0]    SL_LAST   = SL_W'(SLICES - 1);

    state_t              state_reg, state_next;
    logic [OPC_W-1:0]    opcode_reg;
    logic [CNT_W-1:0]    size_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [WADDR_W-1:0]  scan_word_reg;
    logic [SL_W-1:0]     slice_reg;
    logic [WADDR_W-1:0]  mark_word_reg;
    logic [WADDR_W-1:0]  last_word_reg;
    logic [POS_W-1:0]    end_pos_reg;
    logic [WORDS-1:0]    valid_reg;
    logic [PCNT_W-1:0]   cnt_reg [3];

    logic                req_bad;
    logic [POS_W-1:0]    end_pos;
    logic [WORD_W-1:0]   mark_mask;
    logic [WORD_W-1:0]   rd_word;
    logic                scan_last;

    // request checks
    assign req_bad = !(req.opcode inside {OP_FIRST, OP_BEST, OP_WORST}) ||
                     (req.request_size == '0) ||
                     (32'(req.request_size) > UNITS);

    // last unit of the picked run
    assign end_pos = POS_W'({1'b0, scan_stat.pick_start} + (POS_W+1)'(size_reg) - 1'b1);

    // read data with never-written words seen as free
    assign rd_word = (state_reg == ST_LOAD)
                     ? (ram_rdata & {WORD_W{valid_reg[scan_word_reg]}})
                     : (ram_rdata & {WORD_W{valid_reg[mark_word_reg]}});

    assign scan_last = (slice_reg == SL_LAST);

    // units of the current mark word that fall inside the run
    always_comb
    begin
        logic [POS_W-1:0] p;
        for (int b = 0; b < WORD_W; b++)
        begin
            p            = {mark_word_reg, LOC_W'(b)};
            mark_mask[b] = (p >= scan_stat.pick_start) && (p <= end_pos_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = req_bad ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = scan_stat.hit ? ST_MARK_RD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_stat.hit)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (scan_last)
                begin
                    state_next = (scan_word_reg == LAST_WORD) ? ST_CLOSE : ST_LOAD;
                end
            end
            ST_CLOSE:
            begin
                state_next = ST_MARK_RD;
            end
            ST_MARK_RD:
            begin
                state_next = scan_stat.found ? ST_MARK_WR : ST_DONE;
            end
            ST_MARK_WR:
            begin
                if (mark_word_reg == last_word_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs toward scan unit and memory
    always_comb
    begin
        scan_ctrl.clear  = (state_reg == ST_IDLE) && start;
        scan_ctrl.step   = (state_reg == ST_SCAN);
        scan_ctrl.close  = (state_reg == ST_CLOSE);
        scan_ctrl.policy = opcode_reg;
        scan_ctrl.size   = size_reg;
        scan_ctrl.bits   = word_reg[slice_reg * SLICE_W +: SLICE_W];
        scan_ctrl.base   = {scan_word_reg, LOC_W'({slice_reg, 3'b000})};

        ram_wr.we   = 1'b0;
        ram_wr.addr = mark_word_reg;
        ram_wr.data = rd_word | mark_mask;
        ram_raddr   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
            end
            ST_SCAN:
            begin
                ram_raddr = WADDR_W'(scan_word_reg + 1'b1);
            end
            ST_MARK_RD:
            begin
                ram_raddr = scan_stat.pick_start[POS_W-1:LOC_W];
            end
            ST_MARK_WR:
            begin
                ram_wr.we = 1'b1;
                ram_raddr = WADDR_W'(mark_word_reg + 1'b1);
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // handshake and result
    always_comb
    begin
        busy                = (state_reg != ST_IDLE);
        result_valid        = (state_reg == ST_DONE);
        result.granted      = scan_stat.found;
        result.start_unit   = scan_stat.found ? START_W'(scan_stat.pick_start) : '0;
        case (opcode_reg)
            OP_FIRST: result.policy_count = cnt_reg[0];
            OP_BEST:  result.policy_count = cnt_reg[1];
            OP_WORST: result.policy_count = cnt_reg[2];
            default:  result.policy_count = '0;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            opcode_reg    <= '0;
            size_reg      <= '0;
            word_reg      <= '0;
            scan_word_reg <= '0;
            slice_reg     <= '0;
            mark_word_reg <= '0;
            last_word_reg <= '0;
            end_pos_reg   <= '0;
            valid_reg     <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            cnt_reg[2]    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        opcode_reg    <= req.opcode;
                        size_reg      <= CNT_W'(req.request_size);
                        scan_word_reg <= '0;
                    end
                end
                ST_LOAD:
                begin
                    word_reg  <= rd_word;
                    slice_reg <= '0;
                end
                ST_SCAN:
                begin
                    slice_reg <= SL_W'(slice_reg + 1'b1);
                    if (scan_last && scan_word_reg != LAST_WORD)
                    begin
                        scan_word_reg <= WADDR_W'(scan_word_reg + 1'b1);
                    end
                end
                ST_MARK_RD:
                begin
                    mark_word_reg <= scan_stat.pick_start[POS_W-1:LOC_W];
                    last_word_reg <= end_pos[POS_W-1:LOC_W];
                    end_pos_reg   <= end_pos;
                end
                ST_MARK_WR:
                begin
                    valid_reg[mark_word_reg] <= 1'b1;
                    mark_word_reg            <= WADDR_W'(mark_word_reg + 1'b1);
                    if (mark_word_reg == last_word_reg)
                    begin
                        case (opcode_reg)
                            OP_FIRST:
                            begin
                                if (cnt_reg[0] != COUNT_MAX)
                                    cnt_reg[0] <= cnt_reg[0] + 1'b1;
                            end
                            OP_BEST:
                            begin
                                if (cnt_reg[1] != COUNT_MAX)
                                    cnt_reg[1] <= cnt_reg[1] + 1'b1;
                            end
                            OP_WORST:
                            begin
                                if (cnt_reg[2] != COUNT_MAX)
                                    cnt_reg[2] <= cnt_reg[2] + 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- design/bitmap_fit_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_fit_allocator_top: first, best and worst fit unit allocator
// Keeps a used/free bitmap of UNITS units in a word RAM and places runs of
// units under the policy named by each request.
//
//   channel   ports                          transfer
//   request   start, busy, req               start high while busy low
//   result    result_valid, result           one cycle, result_valid high
//
// A request is accepted, then each map word is loaded and walked one 8-unit
// slice per scan step; a close step ends the final run, a decision step
// follows, each map word the placed run touches is rewritten, and a result
// step ends it; an invalid request goes straight to the result. The scan step
// is the pacing unit; first fit ends its scan at the first run long enough.
// Reset clears per-word valid bits, so the map reads as all free at once.
// The receiver cannot stall; busy stays high until the result cycle ends.
// ----------------------------------------------------------------------------
module bitmap_fit_allocator_top
    import bfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    req,
    output logic    busy,
    output logic    result_valid,
    output result_t result
);

    scan_ctrl_t         scan_ctrl;
    scan_stat_t         scan_stat;
    ram_wr_t            ram_wr;
    logic [WADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    // sequencer
    bfa_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .scan_ctrl    (scan_ctrl),
        .scan_stat    (scan_stat),
        .ram_wr       (ram_wr),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    // shared scan unit
    bfa_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .stat  (scan_stat)
    );

    // unit map storage
    bfa_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
